### rtl/unordered_table_engine_macros.svh
// ----------------------------------------------------------------------------
// Unordered table engine assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef UNORDERED_TABLE_ENGINE_MACROS_SVH
`define UNORDERED_TABLE_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define UTE_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("table engine check failed");
`define UTE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("table engine check failed");
`else
`define UTE_ASSERT_NEVER(lbl, clk, rst_n, expr)
`define UTE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`endif
`endif

### rtl/ute_pkg.sv
// ----------------------------------------------------------------------------
// Unordered table engine package
// Transaction types, operation codes, status codes and sequencer states.
// ----------------------------------------------------------------------------
package ute_pkg;

    typedef enum logic [2:0] {
        OP_ADD, OP_GET, OP_SET, OP_REMOVE_AT,
        OP_REMOVE_VALUE, OP_INDEX_OF, OP_COUNT_OF, OP_SORT
    } t_op;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_RANGE     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        t_op         operation;
        logic [7:0]  item_index;
        logic [31:0] item_value;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] read_value;
        logic        found;
        logic [7:0]  found_index;
        logic [8:0]  match_count;
        logic [8:0]  entry_count;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_GETW, S_SRD, S_SCMP, S_RMLAST, S_MOVE,
        S_SI, S_SV, S_SJ, S_SC, S_DONE
    } t_state;

endpackage

### rtl/unordered_table_engine.sv
// ----------------------------------------------------------------------------
// Unordered table engine
// Fixed-capacity table with append, indexed access, swap removal, linear
// search, match count and in-place insertion sort over one memory port pair.
// ----------------------------------------------------------------------------
// channel | direction | handshake              | payload
// in      | input     | i_in_valid / o_in_stall | i_in_data  (t_in)
// out     | output    | o_out_valid / i_out_stall | o_out_data (t_out)
//
// Add and set write in the execute state; get waits on the registered read;
// remove at copies the last entry into the hole. Remove value, index of and
// count of scan the entries one by one, a read state and a compare state each.
// Sort shifts elements one at a time through the single memory read port.
// Reset empties the table; no clearing pass. One transaction at a time.
// ----------------------------------------------------------------------------
`include "unordered_table_engine_macros.svh"

module unordered_table_engine
    import ute_pkg::*;
#(
    parameter int CAPACITY   = 256,
    parameter int ITEM_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = ITEM_WIDTH;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    t_op             r_op, n_op;
    logic [7:0]      r_idx, n_idx;
    logic [IW-1:0]   r_key, n_key;
    logic [IW-1:0]   r_v, n_v;
    logic [CW-1:0]   r_ptr, n_ptr;
    logic [CW-1:0]   r_j, n_j;
    logic [CW-1:0]   r_pos, n_pos;
    logic [CW-1:0]   r_mcount, n_mcount;
    logic [1:0]      r_status, n_status;
    logic [IW-1:0]   r_rd, n_rd;
    logic            r_found, n_found;
    logic            r_out_valid, n_out_valid;
    t_out            r_out, n_out;

    logic            we;
    logic [AW-1:0]   waddr, raddr;
    logic [IW-1:0]   wdata, rdata, cmp_b;
    logic            eq, gt, idx_bad;

    ute_mem #(.DEPTH(CAPACITY), .WIDTH(IW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign cmp_b   = (r_state == S_SC) ? r_v : r_key;
    assign eq      = (rdata == cmp_b);
    assign gt      = (rdata > cmp_b);
    assign idx_bad = (32'(r_idx) >= 32'(r_count));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_op     <= n_op;
        r_idx    <= n_idx;
        r_key    <= n_key;
        r_v      <= n_v;
        r_ptr    <= n_ptr;
        r_j      <= n_j;
        r_pos    <= n_pos;
        r_mcount <= n_mcount;
        r_status <= n_status;
        r_rd     <= n_rd;
        r_found  <= n_found;
        r_out    <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_op        = r_op;
        n_idx       = r_idx;
        n_key       = r_key;
        n_v         = r_v;
        n_ptr       = r_ptr;
        n_j         = r_j;
        n_pos       = r_pos;
        n_mcount    = r_mcount;
        n_status    = r_status;
        n_rd        = r_rd;
        n_found     = r_found;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        we          = 1'b0;
        waddr       = r_pos[AW-1:0];
        wdata       = rdata;
        raddr       = r_ptr[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op     = i_in_data.operation;
                    n_idx    = i_in_data.item_index;
                    n_key    = IW'(i_in_data.item_value);
                    n_ptr    = '0;
                    n_mcount = '0;
                    n_status = ST_OK;
                    n_rd     = '0;
                    n_found  = 1'b0;
                    n_pos    = '0;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_op)
                    OP_ADD: begin
                        if (32'(r_count) >= 32'(CAPACITY)) begin
                            n_status = ST_FULL;
                        end else begin
                            we      = 1'b1;
                            waddr   = r_count[AW-1:0];
                            wdata   = r_key;
                            n_count = CW'(r_count + 1'b1);
                        end
                        n_state = S_DONE;
                    end
                    OP_GET: begin
                        raddr = AW'(r_idx);
                        if (idx_bad) begin
                            n_status = ST_RANGE;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_GETW;
                        end
                    end
                    OP_SET: begin
                        if (idx_bad) begin
                            n_status = ST_RANGE;
                        end else begin
                            we    = 1'b1;
                            waddr = AW'(r_idx);
                            wdata = r_key;
                        end
                        n_state = S_DONE;
                    end
                    OP_REMOVE_AT: begin
                        if (idx_bad) begin
                            n_status = ST_RANGE;
                            n_state  = S_DONE;
                        end else begin
                            n_pos   = CW'(r_idx);
                            n_state = S_RMLAST;
                        end
                    end
                    OP_REMOVE_VALUE, OP_INDEX_OF, OP_COUNT_OF: begin
                        n_state = S_SRD;
                    end
                    OP_SORT: begin
                        n_ptr   = CW'(1);
                        n_state = S_SI;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_GETW: begin
                n_rd    = rdata;
                n_state = S_DONE;
            end
            S_SRD: begin
                if (r_ptr >= r_count) begin
                    n_status = (r_op == OP_COUNT_OF) ? ST_OK : ST_NOT_FOUND;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_SCMP;
                end
            end
            S_SCMP: begin
                if (eq && r_op != OP_COUNT_OF) begin
                    n_found = 1'b1;
                    n_pos   = r_ptr;
                    n_state = (r_op == OP_REMOVE_VALUE) ? S_RMLAST : S_DONE;
                end else begin
                    if (eq) begin
                        n_mcount = CW'(r_mcount + 1'b1);
                    end
                    n_ptr   = CW'(r_ptr + 1'b1);
                    n_state = S_SRD;
                end
            end
            S_RMLAST: begin
                raddr = AW'(r_count - 1'b1);
                if (r_pos == CW'(r_count - 1'b1)) begin
                    n_count = CW'(r_count - 1'b1);
                    n_state = S_DONE;
                end else begin
                    n_state = S_MOVE;
                end
            end
            S_MOVE: begin
                we      = 1'b1;
                n_count = CW'(r_count - 1'b1);
                n_state = S_DONE;
            end
            S_SI: begin
                if (r_ptr >= r_count) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SV;
                end
            end
            S_SV: begin
                n_v     = rdata;
                n_j     = r_ptr;
                n_state = S_SJ;
            end
            S_SJ: begin
                raddr = AW'(r_j - 1'b1);
                if (r_j == '0) begin
                    we      = 1'b1;
                    waddr   = '0;
                    wdata   = r_v;
                    n_ptr   = CW'(r_ptr + 1'b1);
                    n_state = S_SI;
                end else begin
                    n_state = S_SC;
                end
            end
            S_SC: begin
                we    = 1'b1;
                waddr = r_j[AW-1:0];
                if (gt) begin
                    wdata   = rdata;
                    n_j     = CW'(r_j - 1'b1);
                    n_state = S_SJ;
                end else begin
                    wdata   = r_v;
                    n_ptr   = CW'(r_ptr + 1'b1);
                    n_state = S_SI;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.status      = r_status;
                    n_out.read_value  = 32'(r_rd);
                    n_out.found       = r_found;
                    n_out.found_index = 8'(r_pos);
                    n_out.match_count = 9'(r_mcount);
                    n_out.entry_count = 9'(r_count);
                    if (r_op != OP_INDEX_OF) begin
                        n_out.found_index = '0;
                    end
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `UTE_ASSERT_NEVER(a_count_cap, i_clk, i_rst_n, 32'(r_count) > 32'(CAPACITY))
    `UTE_ASSERT_IMPLY(a_scan_ptr, i_clk, i_rst_n, r_state == S_SCMP, r_ptr < r_count)
    `UTE_ASSERT_IMPLY(a_write_addr, i_clk, i_rst_n, we, 32'(waddr) <= 32'(r_count))
endmodule

### rtl/ute_mem.sv
// ----------------------------------------------------------------------------
// Table entry memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ute_mem #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
